// File: design/cylinder_erosion_walker_macros.svh
// Assertion helpers for the erosion walker.
// Each macro samples on the rising edge of clock and is quiet while reset is high.
`ifndef CYLINDER_EROSION_WALKER_MACROS_SVH
`define CYLINDER_EROSION_WALKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CEW_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CEW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/cew_pkg.sv
package cew_pkg;

   // Grid size. COLS must be a power of two so that the column field wraps by truncation.
   localparam int COLS  = 512;
   localparam int ROWS  = 512;
   localparam int COL_W = $clog2(COLS);
   localparam int ROW_W = $clog2(ROWS);
   localparam int CNT_W = $clog2(COLS + 1);

   localparam int FIELD_W    = 9;
   localparam int RAND_W     = 16;
   localparam int ACTION_W   = 3;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 48;

   typedef logic [COL_W-1:0]   col_type;
   typedef logic [ROW_W-1:0]   row_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [COLS-1:0]    word_type;
   typedef logic [FIELD_W-1:0] field_type;
   typedef logic [RAND_W-1:0]  rand_type;

   localparam row_type LAST_ROW = row_type'(ROWS - 1);
   localparam row_type HALF_ROW = row_type'(ROWS / 2);
   localparam col_type LAST_COL = col_type'(COLS - 1);
   localparam cnt_type FULL_CNT = cnt_type'(COLS);

   // Thresholds on the random fraction, scaled by 65536.
   localparam rand_type TH3_A = 16'd21843;
   localparam rand_type TH3_B = 16'd43686;
   localparam rand_type TH4_A = 16'd16384;
   localparam rand_type TH4_B = 16'd32768;
   localparam rand_type TH4_C = 16'd49152;

   typedef enum logic [ACTION_W-1:0] {
      ACT_START_BLUE = 3'd0,
      ACT_START_RED  = 3'd1,
      ACT_STEP       = 3'd2,
      ACT_BOUNDS     = 3'd3,
      ACT_HEIGHT     = 3'd4
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_WALKING = 2'd0,
      STAT_PAINTED = 2'd1,
      STAT_IGNORED = 2'd2,
      STAT_DONE    = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_REPLY,
      ST_TOP_UP,
      ST_TOP_DN,
      ST_BOT_DN,
      ST_BOT_UP,
      ST_HEIGHT
   } state_type;

   typedef struct packed {
      col_type col;
      row_type row;
   } pos_type;

endpackage

// File: design/cew_ram.sv
module cew_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

// File: design/cew_move.sv
module cew_move (
   input  cew_pkg::pos_type  cur,
   input  cew_pkg::rand_type rand_fraction,
   output cew_pkg::pos_type  nxt
);

   logic go_left;
   logic go_up;
   logic go_down;

   // Edge rows offer three moves; the vertical one points back into the grid.
   always_comb begin
      go_left = 1'b0;
      go_up   = 1'b0;
      go_down = 1'b0;
      priority if (cur.row == cew_pkg::LAST_ROW) begin
         go_left = rand_fraction <= cew_pkg::TH3_A;
         go_down = !go_left && (rand_fraction <= cew_pkg::TH3_B);
      end else if (cur.row == '0) begin
         go_left = rand_fraction <= cew_pkg::TH3_A;
         go_up   = !go_left && (rand_fraction <= cew_pkg::TH3_B);
      end else begin
         go_left = rand_fraction <= cew_pkg::TH4_A;
         go_up   = !go_left && (rand_fraction <= cew_pkg::TH4_B);
         go_down = !go_left && !go_up && (rand_fraction <= cew_pkg::TH4_C);
      end
   end

   always_comb begin
      nxt = cur;
      priority if (go_left) begin
         nxt.col = (cur.col == '0) ? cew_pkg::LAST_COL : cur.col - cew_pkg::col_type'(1);
      end else if (go_up) begin
         nxt.row = cur.row + cew_pkg::row_type'(1);
      end else if (go_down) begin
         nxt.row = cur.row - cew_pkg::row_type'(1);
      end else begin
         nxt.col = (cur.col == cew_pkg::LAST_COL) ? '0 : cur.col + cew_pkg::col_type'(1);
      end
   end

endmodule

// File: design/cylinder_erosion_walker.sv
// Competitive erosion walker on a cylinder grid of 512 x 512 one-bit cells (blue 0, red 1).
// The grid is held one row per word in a synchronous memory, and the blue count of each row
// in a second memory. After reset the block sweeps both memories once, one row per cycle,
// so it takes no item until the sweep is done. For a walk start or a walk step, the accept
// cycle addresses the new cell's row, then ST_CHECK checks it and, if the walk ends,
// writes the painted row and its count back. A step with no walk and an unknown action
// pass through ST_REPLY and are answered as ignored. A bounds update runs ST_TOP_UP,
// ST_TOP_DN, ST_BOT_DN and ST_BOT_UP in order, skipping ST_TOP_UP or ST_BOT_DN for a
// boundary already at its grid edge; ST_TOP_DN and ST_BOT_UP repeat for each row that
// their boundary slides over, since each row's count is one memory read. A height query
// scans upward in ST_HEIGHT from the bottom red row. A result waits in the output register;
// an item that finishes while it is still held stalls in place until the result is taken.
`include "cylinder_erosion_walker_macros.svh"

module cylinder_erosion_walker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // column [8:0], rand_fraction [24:9], zero fill
   input  logic [2:0]  req_tuser,   // action [2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // pos_x, pos_y, top_blue, bottom_red, height, zero fill
   output logic [1:0]  rsp_tuser    // status [1:0]
);

   cew_pkg::state_type  state_ff, state_in;
   cew_pkg::row_type    clr_ff, clr_in;
   cew_pkg::col_type    col_ff, col_in;
   cew_pkg::row_type    row_ff, row_in;
   logic                red_ff, red_in;
   logic                active_ff, active_in;
   cew_pkg::row_type    top_ff, top_in;
   cew_pkg::row_type    bot_ff, bot_in;
   cew_pkg::row_type    scan_row_ff, scan_row_in;
   cew_pkg::col_type    scan_col_ff, scan_col_in;
   cew_pkg::status_type pend_ff, pend_in;

   logic                rsp_valid_ff, rsp_valid_in;
   cew_pkg::status_type rsp_status_ff, rsp_status_in;
   cew_pkg::field_type  rsp_x_ff, rsp_x_in;
   cew_pkg::field_type  rsp_y_ff, rsp_y_in;
   cew_pkg::field_type  rsp_top_ff, rsp_top_in;
   cew_pkg::field_type  rsp_bot_ff, rsp_bot_in;
   cew_pkg::field_type  rsp_h_ff, rsp_h_in;

   cew_pkg::action_type req_action;
   cew_pkg::col_type    req_column;
   cew_pkg::rand_type   req_rand;

   cew_pkg::pos_type    cur_pos;
   cew_pkg::pos_type    step_pos;
   cew_pkg::row_type    blue_start;
   cew_pkg::row_type    red_start;
   cew_pkg::word_type   cell_mask;

   logic                out_free;
   logic                load_out;
   cew_pkg::status_type out_status;
   cew_pkg::row_type    out_height;

   logic                grid_we;
   cew_pkg::row_type    grid_waddr;
   cew_pkg::word_type   grid_wdata;
   cew_pkg::row_type    grid_raddr;
   cew_pkg::word_type   grid_q;

   logic                cnt_we;
   cew_pkg::row_type    cnt_waddr;
   cew_pkg::cnt_type    cnt_wdata;
   cew_pkg::row_type    cnt_raddr;
   cew_pkg::cnt_type    cnt_q;

   assign req_action = cew_pkg::action_type'(req_tuser);
   assign req_column = cew_pkg::col_type'(req_tdata[8:0]);
   assign req_rand   = req_tdata[24:9];

   assign cur_pos.col = col_ff;
   assign cur_pos.row = row_ff;

   cew_move u_move (
      .cur           (cur_pos),
      .rand_fraction (req_rand),
      .nxt           (step_pos)
   );

   cew_ram #(
      .WIDTH (cew_pkg::COLS),
      .DEPTH (cew_pkg::ROWS)
   ) u_grid (
      .clock   (clock),
      .wr_en   (grid_we),
      .wr_addr (grid_waddr),
      .wr_data (grid_wdata),
      .rd_addr (grid_raddr),
      .rd_data (grid_q)
   );

   cew_ram #(
      .WIDTH (cew_pkg::CNT_W),
      .DEPTH (cew_pkg::ROWS)
   ) u_count (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_q)
   );

   assign blue_start = (bot_ff != '0) ? bot_ff - cew_pkg::row_type'(1) : '0;
   assign red_start  = (top_ff != cew_pkg::LAST_ROW) ? top_ff + cew_pkg::row_type'(1)
                                                    : cew_pkg::LAST_ROW;
   assign cell_mask  = cew_pkg::word_type'(1) << col_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cew_pkg::ST_CLEAR;
         clr_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         red_ff       <= 1'b0;
         active_ff    <= 1'b0;
         top_ff       <= cew_pkg::HALF_ROW - cew_pkg::row_type'(1);
         bot_ff       <= cew_pkg::HALF_ROW;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         red_ff       <= red_in;
         active_ff    <= active_in;
         top_ff       <= top_in;
         bot_ff       <= bot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_row_ff   <= scan_row_in;
      scan_col_ff   <= scan_col_in;
      pend_ff       <= pend_in;
      rsp_status_ff <= rsp_status_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_bot_ff    <= rsp_bot_in;
      rsp_h_ff      <= rsp_h_in;
   end

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      red_in      = red_ff;
      active_in   = active_ff;
      top_in      = top_ff;
      bot_in      = bot_ff;
      scan_row_in = scan_row_ff;
      scan_col_in = scan_col_ff;
      pend_in     = pend_ff;
      req_tready  = 1'b0;
      load_out    = 1'b0;
      out_status  = cew_pkg::STAT_DONE;
      out_height  = '0;
      grid_we     = 1'b0;
      grid_waddr  = row_ff;
      grid_wdata  = grid_q;
      grid_raddr  = row_ff;
      cnt_we      = 1'b0;
      cnt_waddr   = row_ff;
      cnt_wdata   = cnt_q;
      cnt_raddr   = row_ff;

      unique case (state_ff)
         cew_pkg::ST_CLEAR: begin
            grid_we    = 1'b1;
            grid_waddr = clr_ff;
            grid_wdata = (clr_ff >= cew_pkg::HALF_ROW) ? '1 : '0;
            cnt_we     = 1'b1;
            cnt_waddr  = clr_ff;
            cnt_wdata  = (clr_ff >= cew_pkg::HALF_ROW) ? '0 : cew_pkg::FULL_CNT;
            clr_in     = clr_ff + cew_pkg::row_type'(1);
            if (clr_ff == cew_pkg::LAST_ROW) begin
               state_in = cew_pkg::ST_IDLE;
            end
         end

         cew_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               unique case (req_action)
                  cew_pkg::ACT_START_BLUE, cew_pkg::ACT_START_RED: begin
                     red_in     = (req_action == cew_pkg::ACT_START_RED);
                     col_in     = req_column;
                     row_in     = (req_action == cew_pkg::ACT_START_RED) ? red_start
                                                                          : blue_start;
                     grid_raddr = row_in;
                     cnt_raddr  = row_in;
                     state_in   = cew_pkg::ST_CHECK;
                  end
                  cew_pkg::ACT_STEP: begin
                     if (active_ff) begin
                        col_in     = step_pos.col;
                        row_in     = step_pos.row;
                        grid_raddr = row_in;
                        cnt_raddr  = row_in;
                        state_in   = cew_pkg::ST_CHECK;
                     end else begin
                        pend_in  = cew_pkg::STAT_IGNORED;
                        state_in = cew_pkg::ST_REPLY;
                     end
                  end
                  cew_pkg::ACT_BOUNDS: begin
                     if (top_ff != cew_pkg::LAST_ROW) begin
                        cnt_raddr = top_ff + cew_pkg::row_type'(1);
                        state_in  = cew_pkg::ST_TOP_UP;
                     end else begin
                        cnt_raddr = top_ff;
                        state_in  = cew_pkg::ST_TOP_DN;
                     end
                  end
                  cew_pkg::ACT_HEIGHT: begin
                     scan_col_in = req_column;
                     scan_row_in = bot_ff;
                     grid_raddr  = bot_ff;
                     state_in    = cew_pkg::ST_HEIGHT;
                  end
                  default: begin
                     pend_in  = cew_pkg::STAT_IGNORED;
                     state_in = cew_pkg::ST_REPLY;
                  end
               endcase
            end
         end

         // The row word of the walker's cell is in grid_q; a cell of the other
         // color ends the walk and is painted along with its row count.
         cew_pkg::ST_CHECK: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = cew_pkg::ST_IDLE;
               if (grid_q[col_ff] != red_ff) begin
                  grid_we    = 1'b1;
                  grid_wdata = red_ff ? (grid_q | cell_mask) : (grid_q & ~cell_mask);
                  cnt_we     = 1'b1;
                  if (red_ff) begin
                     cnt_wdata = (cnt_q != '0) ? cnt_q - cew_pkg::cnt_type'(1) : cnt_q;
                  end else begin
                     cnt_wdata = (cnt_q < cew_pkg::FULL_CNT) ? cnt_q + cew_pkg::cnt_type'(1)
                                                             : cnt_q;
                  end
                  active_in  = 1'b0;
                  out_status = cew_pkg::STAT_PAINTED;
               end else begin
                  active_in  = 1'b1;
                  out_status = cew_pkg::STAT_WALKING;
               end
            end
         end

         cew_pkg::ST_REPLY: begin
            if (out_free) begin
               load_out   = 1'b1;
               out_status = pend_ff;
               state_in   = cew_pkg::ST_IDLE;
            end
         end

         cew_pkg::ST_TOP_UP: begin
            if (cnt_q != '0) begin
               top_in = top_ff + cew_pkg::row_type'(1);
            end
            cnt_raddr = top_in;
            state_in  = cew_pkg::ST_TOP_DN;
         end

         cew_pkg::ST_TOP_DN: begin
            if (top_ff != '0 && cnt_q == '0) begin
               top_in    = top_ff - cew_pkg::row_type'(1);
               cnt_raddr = top_in;
            end else if (bot_ff != '0) begin
               cnt_raddr = bot_ff - cew_pkg::row_type'(1);
               state_in  = cew_pkg::ST_BOT_DN;
            end else begin
               cnt_raddr = bot_ff;
               state_in  = cew_pkg::ST_BOT_UP;
            end
         end

         cew_pkg::ST_BOT_DN: begin
            if (cnt_q != cew_pkg::FULL_CNT) begin
               bot_in = bot_ff - cew_pkg::row_type'(1);
            end
            cnt_raddr = bot_in;
            state_in  = cew_pkg::ST_BOT_UP;
         end

         cew_pkg::ST_BOT_UP: begin
            cnt_raddr = bot_ff;
            if (bot_ff != cew_pkg::LAST_ROW && cnt_q == cew_pkg::FULL_CNT) begin
               bot_in    = bot_ff + cew_pkg::row_type'(1);
               cnt_raddr = bot_in;
            end else if (out_free) begin
               load_out   = 1'b1;
               out_status = cew_pkg::STAT_DONE;
               state_in   = cew_pkg::ST_IDLE;
            end
         end

         cew_pkg::ST_HEIGHT: begin
            grid_raddr = scan_row_ff;
            if (scan_row_ff != cew_pkg::LAST_ROW && !grid_q[scan_col_ff]) begin
               scan_row_in = scan_row_ff + cew_pkg::row_type'(1);
               grid_raddr  = scan_row_in;
            end else if (out_free) begin
               load_out   = 1'b1;
               out_status = cew_pkg::STAT_DONE;
               out_height = scan_row_ff;
               state_in   = cew_pkg::ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_bot_in    = rsp_bot_ff;
      rsp_h_in      = rsp_h_ff;
      if (load_out) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = out_status;
         rsp_x_in      = cew_pkg::field_type'(col_in);
         rsp_y_in      = cew_pkg::field_type'(row_in);
         rsp_top_in    = cew_pkg::field_type'(top_in);
         rsp_bot_in    = cew_pkg::field_type'(bot_in);
         rsp_h_in      = cew_pkg::field_type'(out_height);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_h_ff, rsp_bot_ff, rsp_top_ff, rsp_y_ff, rsp_x_ff};

   `CEW_ASSERT_IMPLY(a_paint_only_with_result, grid_we && state_ff != cew_pkg::ST_CLEAR, load_out && out_status == cew_pkg::STAT_PAINTED, "grid written outside a painting result")
   `CEW_ASSERT_NEXT(a_paint_ends_walk, state_ff == cew_pkg::ST_CHECK && grid_we, !active_ff, "walk still active after painting")
   `CEW_ASSERT_IMPLY(a_count_in_range, cnt_we, cnt_wdata <= cew_pkg::FULL_CNT, "row blue count above the row width")
   `CEW_ASSERT_IMPLY(a_no_result_in_clear, state_ff == cew_pkg::ST_CLEAR, !rsp_valid_ff && !load_out, "result produced during the clearing sweep")

endmodule
